>>> hdl/vdi_pkg.sv
package vdi_pkg;

    // Width of one attribute bit pattern
    localparam int unsigned ATTR_W = 32;

    // Width of the vertex index result field
    localparam int unsigned OUT_IDX_W = 12;

    // One vertex as stored in the key memory, pairs in the order of the key words
    typedef struct packed {
        logic [ATTR_W-1:0] pos_x;
        logic [ATTR_W-1:0] pos_y;
        logic [ATTR_W-1:0] pos_z;
        logic [ATTR_W-1:0] tex_u;
        logic [ATTR_W-1:0] tex_v;
        logic [ATTR_W-1:0] norm_x;
        logic [ATTR_W-1:0] norm_y;
        logic [ATTR_W-1:0] norm_z;
    } t_vertex;

    localparam int unsigned KEY_W = $bits(t_vertex);

endpackage

>>> hdl/vdi_slot_table.sv
// Hash slot table: each slot holds the index of the vertex placed there.
module vdi_slot_table #(
    parameter int unsigned SLOT_W = 13,
    parameter int unsigned IDX_W  = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [IDX_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [IDX_W-1:0]  o_rdata
);

    localparam int unsigned DEPTH = 2 ** SLOT_W;

    logic [IDX_W-1:0] r_mem [0:DEPTH-1];
    logic [IDX_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/vdi_key_store.sv
// Unique-vertex key store, addressed by vertex index. Each entry also keeps
// the hash slot that points at it, so a stale slot from an earlier mesh
// can be told apart from a live one.
module vdi_key_store #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned IDX_W  = 12,
    parameter int unsigned SLOT_W = 13
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  logic [SLOT_W-1:0]  i_wslot,
    input  vdi_pkg::t_vertex   i_wkey,
    input  logic               i_re,
    input  logic [IDX_W-1:0]   i_raddr,
    output logic [SLOT_W-1:0]  o_rslot,
    output vdi_pkg::t_vertex   o_rkey
);

    localparam int unsigned ENTRY_W = SLOT_W + vdi_pkg::KEY_W;

    logic [ENTRY_W-1:0] r_mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wslot, i_wkey};
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rslot = r_rdata[ENTRY_W-1:vdi_pkg::KEY_W];
    assign o_rkey  = vdi_pkg::t_vertex'(r_rdata[vdi_pkg::KEY_W-1:0]);

endmodule

>>> hdl/vertex_dedup_indexer.sv
// Vertex index builder. Raise start for one cycle with a vertex while busy is
// low; the result appears on the o_ ports with o_valid high for exactly one
// cycle and must be captured then, since this block cannot be stalled. A vertex
// is looked up in an open-addressed hash table of 2**(clog2(MAX_VERTICES)+1)
// slots with linear probing. An item passes through S_PROBE, S_ENTRY and
// S_CHECK once for each probe that it takes, until one settles it; one probe is
// a slot table read followed by a key store read, then a compare. Start_mesh
// empties the table at once, with no sweep. After reset the slot table is
// cleared in a pass over every slot, during which busy stays high. When the
// table holds MAX_VERTICES vertices, a vertex with no match is reported with
// o_table_full and is not stored.
module vertex_dedup_indexer #(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_start_mesh,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_pos_x,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_pos_y,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_pos_z,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_tex_u,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_tex_v,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_norm_x,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_norm_y,
    input  logic [vdi_pkg::ATTR_W-1:0]       i_norm_z,
    output logic                             o_valid,
    output logic [vdi_pkg::OUT_IDX_W-1:0]    o_vertex_index,
    output logic                             o_is_new,
    output logic                             o_table_full,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_pos_x,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_pos_y,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_pos_z,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_tex_u,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_tex_v,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_norm_x,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_norm_y,
    output logic [vdi_pkg::ATTR_W-1:0]       o_new_norm_z
);

    localparam int unsigned IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int unsigned SLOT_W = IDX_W + 1;
    localparam int unsigned KEY_W  = vdi_pkg::KEY_W;
    localparam int unsigned ATTR_W = vdi_pkg::ATTR_W;
    localparam int unsigned OIW    = vdi_pkg::OUT_IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_ENTRY,
        S_CHECK
    } t_state;

    t_state              r_state;
    vdi_pkg::t_vertex    r_key;
    logic [SLOT_W-1:0]   r_probe;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_clr;

    vdi_pkg::t_vertex    in_key;
    logic [SLOT_W-1:0]   in_hash;
    logic                accept;

    logic [IDX_W-1:0]    slot_rdata;
    logic [SLOT_W-1:0]   key_rslot;
    vdi_pkg::t_vertex    key_rdata;

    logic                slot_we;
    logic [SLOT_W-1:0]   slot_waddr;
    logic [IDX_W-1:0]    slot_wdata;
    logic                key_we;

    logic                live;
    logic                hit;
    logic                full;
    logic                insert;
    logic [IDX_W+OIW-1:0] hit_idx_ext;
    logic [IDX_W+OIW-1:0] new_idx_ext;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign in_key = '{pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                      tex_u: i_tex_u, tex_v: i_tex_v,
                      norm_x: i_norm_x, norm_y: i_norm_y, norm_z: i_norm_z};

    // Hash: XOR fold of the key, each attribute word rotated by its own offset
    always_comb begin
        in_hash = '0;
        for (int unsigned b = 0; b < KEY_W; b++) begin
            in_hash[(b + (b / ATTR_W) * 7) % SLOT_W] ^= in_key[b];
        end
    end

    // Probe outcome: a slot is live only if its index is in use and that
    // entry was placed through this very slot
    assign live   = (CNT_W'(r_idx) < r_count) && (key_rslot == r_probe);
    assign hit    = live && (key_rdata == r_key);
    assign full   = (r_count == CNT_W'(MAX_VERTICES));
    assign insert = (r_state == S_CHECK) && !live && !full;

    assign hit_idx_ext = {{OIW{1'b0}}, r_idx};
    assign new_idx_ext = {{OIW{1'b0}}, r_count[IDX_W-1:0]};

    // Memory write controls
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_probe;
        slot_wdata = r_count[IDX_W-1:0];
        if (r_state == S_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = r_clr;
            slot_wdata = '0;
        end else if (insert) begin
            slot_we = 1'b1;
        end
    end
    assign key_we = insert;

    vdi_slot_table #(
        .SLOT_W (SLOT_W),
        .IDX_W  (IDX_W)
    ) u_slot_table (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (r_state == S_PROBE),
        .i_raddr (r_probe),
        .o_rdata (slot_rdata)
    );

    vdi_key_store #(
        .DEPTH  (MAX_VERTICES),
        .IDX_W  (IDX_W),
        .SLOT_W (SLOT_W)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wslot (r_probe),
        .i_wkey  (r_key),
        .i_re    (r_state == S_ENTRY),
        .i_raddr (slot_rdata),
        .o_rslot (key_rslot),
        .o_rkey  (key_rdata)
    );

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_key   <= in_key;
                        r_probe <= in_hash;
                        if (i_start_mesh) begin
                            r_count <= '0;
                        end
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_state <= S_ENTRY;
                end
                S_ENTRY: begin
                    r_idx   <= slot_rdata;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (hit) begin
                        o_valid        <= 1'b1;
                        o_vertex_index <= hit_idx_ext[OIW-1:0];
                        o_is_new       <= 1'b0;
                        o_table_full   <= 1'b0;
                        o_new_pos_x    <= '0;
                        o_new_pos_y    <= '0;
                        o_new_pos_z    <= '0;
                        o_new_tex_u    <= '0;
                        o_new_tex_v    <= '0;
                        o_new_norm_x   <= '0;
                        o_new_norm_y   <= '0;
                        o_new_norm_z   <= '0;
                        r_state        <= S_IDLE;
                    end else if (live) begin
                        // occupied by another vertex: next slot
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_PROBE;
                    end else if (full) begin
                        o_valid        <= 1'b1;
                        o_vertex_index <= '0;
                        o_is_new       <= 1'b0;
                        o_table_full   <= 1'b1;
                        o_new_pos_x    <= '0;
                        o_new_pos_y    <= '0;
                        o_new_pos_z    <= '0;
                        o_new_tex_u    <= '0;
                        o_new_tex_v    <= '0;
                        o_new_norm_x   <= '0;
                        o_new_norm_y   <= '0;
                        o_new_norm_z   <= '0;
                        r_state        <= S_IDLE;
                    end else begin
                        o_valid        <= 1'b1;
                        o_vertex_index <= new_idx_ext[OIW-1:0];
                        o_is_new       <= 1'b1;
                        o_table_full   <= 1'b0;
                        o_new_pos_x    <= r_key.pos_x;
                        o_new_pos_y    <= r_key.pos_y;
                        o_new_pos_z    <= r_key.pos_z;
                        o_new_tex_u    <= r_key.tex_u;
                        o_new_tex_v    <= r_key.tex_v;
                        o_new_norm_x   <= r_key.norm_x;
                        o_new_norm_y   <= r_key.norm_y;
                        o_new_norm_z   <= r_key.norm_z;
                        r_count        <= r_count + 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    // A result only follows a compare step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_CHECK))
        else $error("result strobe without a compare step");

    // New and full are exclusive
    a_new_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_table_full))
        else $error("result both new and full");

    // Each insert grows the table by exactly one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        insert |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance the count");

    // An inserted vertex is reported as new
    a_insert_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        insert |=> (o_valid && o_is_new))
        else $error("insert without a new-vertex result");

endmodule
